[rtl/assert_macros.svh]
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PIDC_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true outside reset
`define PIDC_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/pidc_pkg.sv]
`default_nettype none

package pidc_pkg;

	// field and register widths
	localparam int GAIN_W    = 16;
	localparam int ERR_W     = 17;
	localparam int DIFF_W    = 18;
	localparam int ACC_W     = 33;
	localparam int WIDE_W    = 58;
	localparam int Q_FRAC    = 16;
	localparam int GAIN_FRAC = 8;

	// shared multiplier
	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// serial divider, two quotient bits per cycle
	localparam int DIV_W       = WIDE_W;
	localparam int DEN_W       = 16;
	localparam int DIV_RADIX_B = 2;
	localparam int DIV_STEPS   = DIV_W / DIV_RADIX_B;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam int MS_PER_S         = 1000;
	localparam int Q_ROUND          = (1 << Q_FRAC) - 1;
	localparam int RESET_LIMIT_HIGH = 255;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_HIGH = 3'd5;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

[rtl/pidc_mul.sv]
`default_nettype none

module pidc_mul import pidc_pkg::*; (
	input  wire logic                      clk,
	input  wire logic signed [MUL_A_W-1:0] a,
	input  wire logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0]      prod
);

	// registered signed product, one issue per cycle
	always_ff @(posedge clk) begin
		prod <= a * b;
	end

endmodule

`default_nettype wire

[rtl/pidc_div.sv]
`default_nettype none
`include "assert_macros.svh"

module pidc_div import pidc_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [DIV_W-1:0] dividend,
	input  wire logic [DEN_W-1:0]        divisor,
	output logic signed [DIV_W-1:0]      quotient,
	output div_status_t                  status
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [DIV_W-1:0]     work_q;

	logic [DEN_W-1:0]     rem_n;
	logic [DIV_W-1:0]     work_n;
	logic [DEN_W:0]       trial;
	logic                 take;
	logic [DIV_W-1:0]     mag;

	assign mag = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);

	// restoring steps, quotient bits shift in from the bottom
	always_comb begin
		rem_n  = rem_q;
		work_n = work_q;
		trial  = '0;
		take   = 1'b0;
		for (int i = 0; i < DIV_RADIX_B; i++) begin
			trial = {rem_n, work_n[DIV_W-1]};
			take  = (trial >= {1'b0, den_q});
			if (take) begin
				trial = trial - {1'b0, den_q};
			end
			rem_n  = trial[DEN_W-1:0];
			work_n = {work_n[DIV_W-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q  <= '0;
			work_q <= mag;
			neg_q  <= dividend[DIV_W-1];
			den_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= rem_n;
			work_q <= work_n;
		end
	end

	assign quotient    = neg_q ? DIV_W'(-work_q) : work_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

	`PIDC_ASSERT(a_div_done_pulse, clk, arst_n, done_q |=> !done_q, "divider done held")
	`PIDC_ASSERT(a_div_last_step, clk, arst_n, (busy_q && cnt_q == '0) |=> (done_q && !busy_q), "divider missed done")

endmodule

`default_nettype wire

[rtl/pid_controller_clamped_unit.sv]
`default_nettype none
`include "assert_macros.svh"

// PID controller with integral clamp. Each item carries a measurement and the
// milliseconds since the previous item; the block forms error = target -
// measurement, P = gain_p * error, adds gain_i * error * elapsed_ms / 1000 to a
// Q16.16 integral that is clamped to [limit_low, limit_high], forms
// D = gain_d * (error - previous error) * 1000 / elapsed_ms, and returns the
// clamped sum truncated to an integer as drive. With elapsed_ms zero the
// integral is only re-clamped and D is zero. All divisions truncate toward
// zero. Gains are signed Q8.8. One item is worked at a time. Each item goes
// through six multiplier slots on the shared 35x18 multiplier (five issues
// and one capture), two passes of the radix-4 serial divider (29 steps plus
// the done step, for the /1000 and the /elapsed_ms, both skipped when
// elapsed_ms is zero), four add and clamp steps and the output load. A
// finished result waits in the output register; the next item is taken
// while it waits. Configuration writes land at once through the write port
// and an index beyond the list is ignored.
module pid_controller_clamped_unit import pidc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write port
	input  wire logic                 cfg_wen,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [GAIN_W-1:0]    cfg_data,
	// input items
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic signed [15:0]   measurement,
	input  wire logic [15:0]          elapsed_ms,
	// result items
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [15:0]        drive
);

	// sequencer states
	typedef enum logic [13:0] {
		S_IDLE   = 14'h0001,
		S_MP     = 14'h0002,
		S_MI1    = 14'h0004,
		S_MI2    = 14'h0008,
		S_MD1    = 14'h0010,
		S_MD2    = 14'h0020,
		S_MD3    = 14'h0040,
		S_DIVI   = 14'h0080,
		S_DIVD   = 14'h0100,
		S_ICLAMP = 14'h0200,
		S_SUM1   = 14'h0400,
		S_SUM2   = 14'h0800,
		S_OCLAMP = 14'h1000,
		S_OUT    = 14'h2000
	} state_t;

	state_t state_q, state_d;

	// configuration registers
	logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic signed [GAIN_W-1:0] target_q, limit_low_q, limit_high_q;

	// controller state
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ERR_W-1:0] prev_err_q;

	// per item working registers
	logic signed [ERR_W-1:0]  err_q;
	logic [15:0]              dt_q;
	logic signed [ACC_W-1:0]  p_q;
	logic signed [49:0]       inum_q;
	logic signed [44:0]       dnum_q;
	logic signed [WIDE_W-1:0] wide_q;
	logic signed [WIDE_W-1:0] dterm_q;
	logic signed [ACC_W-1:0]  clamp_q;
	logic signed [15:0]       drive_q;
	logic                     out_valid_q;

	// shared units
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod;
	logic                      div_start;
	logic signed [DIV_W-1:0]   div_dividend;
	logic signed [DIV_W-1:0]   div_quot;
	div_status_t               div_status;

	logic signed [DIFF_W-1:0] diff;
	logic signed [WIDE_W-1:0] p_wide, acc_wide, inum_wide, dnum_wide, clamp_w;
	logic signed [ACC_W-1:0]  round_adj;
	logic signed [15:0]       drive_w;
	logic signed [ACC_W-1:0]  lo_acc, hi_acc;
	logic                     in_take, out_load;

	// clamp in Q16.16: below low wins, then above high
	function automatic logic signed [WIDE_W-1:0] clamp_q16(
		input logic signed [WIDE_W-1:0] x,
		input logic signed [GAIN_W-1:0] lo,
		input logic signed [GAIN_W-1:0] hi
	);
		logic signed [WIDE_W-1:0] lo_w;
		logic signed [WIDE_W-1:0] hi_w;
		lo_w = {{(WIDE_W-GAIN_W-Q_FRAC){lo[GAIN_W-1]}}, lo, {Q_FRAC{1'b0}}};
		hi_w = {{(WIDE_W-GAIN_W-Q_FRAC){hi[GAIN_W-1]}}, hi, {Q_FRAC{1'b0}}};
		if (x < lo_w) begin
			return lo_w;
		end else if (x > hi_w) begin
			return hi_w;
		end
		return x;
	endfunction

	pidc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	pidc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (state_q == S_MD3 ? DEN_W'(MS_PER_S) : dt_q),
		.quotient (div_quot),
		.status   (div_status)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign in_take   = in_valid && in_ready;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// error change, one bit wider than the error
	assign diff = {err_q[ERR_W-1], err_q} - {prev_err_q[ERR_W-1], prev_err_q};

	// operands lined up in Q16.16 over the wide word
	assign p_wide    = {{(WIDE_W-ACC_W-GAIN_FRAC){p_q[ACC_W-1]}}, p_q, {GAIN_FRAC{1'b0}}};
	assign acc_wide  = {{(WIDE_W-ACC_W){acc_q[ACC_W-1]}}, acc_q};
	assign inum_wide = {inum_q, {GAIN_FRAC{1'b0}}};
	assign dnum_wide = {{(WIDE_W-45-GAIN_FRAC){dnum_q[44]}}, dnum_q, {GAIN_FRAC{1'b0}}};

	// one clamp unit, used for the integral and for the output sum
	assign clamp_w = clamp_q16(wide_q, limit_low_q, limit_high_q);

	// truncate toward zero on the way out of Q16.16
	assign round_adj = clamp_q + (clamp_q[ACC_W-1] ? ACC_W'(Q_ROUND) : ACC_W'(0));
	assign drive_w   = round_adj[Q_FRAC+15:Q_FRAC];

	assign lo_acc = {limit_low_q[GAIN_W-1], limit_low_q, {Q_FRAC{1'b0}}};
	assign hi_acc = {limit_high_q[GAIN_W-1], limit_high_q, {Q_FRAC{1'b0}}};

	// sequencer: multiplier issue slots, then divider passes unless no time passed, then add and clamp steps
	always_comb begin
		state_d      = state_q;
		mul_a        = '0;
		mul_b        = '0;
		div_start    = 1'b0;
		div_dividend = dnum_wide;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_MP;
				end
			end
			S_MP: begin
				mul_a   = {{(MUL_A_W-GAIN_W){gain_p_q[GAIN_W-1]}}, gain_p_q};
				mul_b   = {err_q[ERR_W-1], err_q};
				state_d = S_MI1;
			end
			S_MI1: begin
				mul_a   = {{(MUL_A_W-GAIN_W){gain_i_q[GAIN_W-1]}}, gain_i_q};
				mul_b   = {err_q[ERR_W-1], err_q};
				state_d = S_MI2;
			end
			S_MI2: begin
				// gain_i * error back into the multiplier with the elapsed time
				mul_a   = prod[MUL_A_W-1:0];
				mul_b   = {2'b00, dt_q};
				state_d = S_MD1;
			end
			S_MD1: begin
				mul_a   = {{(MUL_A_W-GAIN_W){gain_d_q[GAIN_W-1]}}, gain_d_q};
				mul_b   = diff;
				state_d = S_MD2;
			end
			S_MD2: begin
				mul_a   = prod[MUL_A_W-1:0];
				mul_b   = MUL_B_W'(MS_PER_S);
				state_d = S_MD3;
			end
			S_MD3: begin
				if (dt_q == '0) begin
					state_d = S_ICLAMP;
				end else begin
					div_start    = 1'b1;
					div_dividend = inum_wide;
					state_d      = S_DIVI;
				end
			end
			S_DIVI: begin
				if (div_status.done) begin
					div_start = 1'b1;
					state_d   = S_DIVD;
				end
			end
			S_DIVD: begin
				if (div_status.done) begin
					state_d = S_ICLAMP;
				end
			end
			S_ICLAMP: state_d = S_SUM1;
			S_SUM1:   state_d = S_SUM2;
			S_SUM2:   state_d = S_OCLAMP;
			S_OCLAMP: state_d = S_OUT;
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// configuration registers, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q     <= '0;
			gain_i_q     <= '0;
			gain_d_q     <= '0;
			target_q     <= '0;
			limit_low_q  <= '0;
			limit_high_q <= GAIN_W'(RESET_LIMIT_HIGH);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_GAIN_P:     gain_p_q     <= cfg_data;
				CFG_GAIN_I:     gain_i_q     <= cfg_data;
				CFG_GAIN_D:     gain_d_q     <= cfg_data;
				CFG_TARGET:     target_q     <= cfg_data;
				CFG_LIMIT_LOW:  limit_low_q  <= cfg_data;
				CFG_LIMIT_HIGH: limit_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control state and controller memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= '0;
			prev_err_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_ICLAMP) begin
				acc_q <= clamp_w[ACC_W-1:0];
			end
			if (out_load) begin
				prev_err_q  <= err_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			err_q <= {target_q[GAIN_W-1], target_q} - {measurement[15], measurement};
			dt_q  <= elapsed_ms;
		end
		if (out_load) begin
			drive_q <= drive_w;
		end
		case (state_q)
			S_MI1: p_q    <= prod[ACC_W-1:0];
			S_MD1: inum_q <= prod[49:0];
			S_MD3: begin
				dnum_q <= prod[44:0];
				if (dt_q == '0) begin
					// no time passed: integral only re-clamped, no derivative
					wide_q  <= acc_wide;
					dterm_q <= '0;
				end
			end
			S_DIVI: begin
				if (div_status.done) begin
					wide_q <= acc_wide + div_quot;
				end
			end
			S_DIVD: begin
				if (div_status.done) begin
					dterm_q <= div_quot;
				end
			end
			S_SUM1:   wide_q  <= p_wide + acc_wide;
			S_SUM2:   wide_q  <= wide_q + dterm_q;
			S_OCLAMP: clamp_q <= clamp_w[ACC_W-1:0];
			default: ;
		endcase
	end

	`PIDC_ASSERT(a_take_goes_busy, clk, arst_n, in_take |=> !in_ready, "ready after take")
	`PIDC_ASSERT_NEVER(a_div_start_free, clk, arst_n, div_start && div_status.busy, "divider restarted while busy")
	`PIDC_ASSERT(a_sum_in_limits, clk, arst_n, (state_q == S_OCLAMP && limit_low_q <= limit_high_q) |=> (clamp_q >= $past(lo_acc) && clamp_q <= $past(hi_acc)), "clamped sum out of limits")

endmodule

`default_nettype wire

[dv/pid_controller_clamped_unit_checker.sv]
`timescale 1ns / 100ps

module pid_controller_clamped_unit_checker import pidc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic signed [15:0]   measurement,
	input  logic [15:0]          elapsed_ms,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic signed [15:0]   drive,
	output int                   pending,
	output int                   failures
);

	localparam longint Q_ONE     = 64'sd1 <<< Q_FRAC;
	localparam longint GAIN_TO_Q = 64'sd1 <<< (Q_FRAC - GAIN_FRAC);

	typedef struct packed {
		logic signed [15:0] drive;
	} drive_item_t;

	logic signed [GAIN_W-1:0] gain_p, gain_i, gain_d, target;
	logic signed [GAIN_W-1:0] limit_low, limit_high;
	logic signed [ACC_W-1:0]  integral_acc;
	logic signed [ERR_W-1:0]  last_error;
	drive_item_t              drive_q[$];

	function automatic longint clamp_to_limits(longint x);
		longint lo, hi;
		lo = longint'(limit_low) * Q_ONE;
		hi = longint'(limit_high) * Q_ONE;
		if (x < lo)
			return lo;
		if (x > hi)
			return hi;
		return x;
	endfunction

	// one control step, updates integral and last error
	function automatic drive_item_t control_step(logic signed [15:0] meas, logic [15:0] dt);
		longint      err, p_term, d_term, acc, sum;
		drive_item_t res;
		err    = longint'(target) - longint'(meas);
		p_term = longint'(gain_p) * err * GAIN_TO_Q;
		d_term = 0;
		acc    = longint'(integral_acc);
		if (dt != 0) begin
			acc    = acc + (longint'(gain_i) * err * longint'(dt) * GAIN_TO_Q) / MS_PER_S;
			d_term = (longint'(gain_d) * (err - longint'(last_error)) * MS_PER_S * GAIN_TO_Q)
				/ longint'(dt);
		end
		acc          = clamp_to_limits(acc);
		integral_acc = acc[ACC_W-1:0];
		sum          = clamp_to_limits(p_term + acc + d_term);
		last_error   = err[ERR_W-1:0];
		res.drive    = 16'(sum / Q_ONE);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		drive_item_t want;
		if (!arst_n) begin
			gain_p       = '0;
			gain_i       = '0;
			gain_d       = '0;
			target       = '0;
			limit_low    = '0;
			limit_high   = 16'(RESET_LIMIT_HIGH);
			integral_acc = '0;
			last_error   = '0;
			drive_q.delete();
			failures     = 0;
			pending     <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					CFG_GAIN_P:     gain_p = cfg_data;
					CFG_GAIN_I:     gain_i = cfg_data;
					CFG_GAIN_D:     gain_d = cfg_data;
					CFG_TARGET:     target = cfg_data;
					CFG_LIMIT_LOW:  limit_low = cfg_data;
					CFG_LIMIT_HIGH: limit_high = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (drive_q.size() == 0) begin
					$error("drive item with nothing expected: actual %0d", drive);
					failures++;
				end else begin
					want = drive_q.pop_front();
					if (drive !== want.drive) begin
						$error("drive mismatch: expected %0d, actual %0d", want.drive, drive);
						failures++;
					end
				end
			end
			if (in_valid && in_ready)
				drive_q.push_back(control_step(measurement, elapsed_ms));
			pending <= drive_q.size();
		end
	end

endmodule

[dv/pid_controller_clamped_unit_test.sv]
`timescale 1ns / 100ps

module pid_controller_clamped_unit_test;
	import pidc_pkg::*;

	// run length and pacing
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 100;
	localparam int RANDOM_PHASES = 23;
	localparam int PHASE_ITEMS   = 50;
	localparam int MAX_GAP       = 12;

	// indexes past the register list, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [GAIN_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [15:0]   measurement;
	logic [15:0]          elapsed_ms;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [15:0]   drive;

	int pending;
	int failures;
	int cycles = 0;
	// when set, neither side inserts gaps or stalls
	bit calm = 1'b0;

	pid_controller_clamped_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.measurement (measurement),
		.elapsed_ms  (elapsed_ms),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drive       (drive)
	);

	// prediction and comparison live here, the top only drives and judges
	pid_controller_clamped_unit_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.measurement (measurement),
		.elapsed_ms  (elapsed_ms),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drive       (drive),
		.pending     (pending),
		.failures    (failures)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("pid_controller_clamped_unit test failed");
			$finish;
		end
	end

	// one register write per edge, caller lowers the enable after a group
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// full register set, spare indexes get random junk first
	task automatic load_settings(logic signed [15:0] gp, logic signed [15:0] gi,
			logic signed [15:0] gd, logic signed [15:0] tgt,
			logic signed [15:0] lo, logic signed [15:0] hi);
		write_reg(CFG_SPARE_A, 16'($urandom));
		write_reg(CFG_SPARE_B, 16'($urandom));
		write_reg(CFG_GAIN_P, gp);
		write_reg(CFG_GAIN_I, gi);
		write_reg(CFG_GAIN_D, gd);
		write_reg(CFG_TARGET, tgt);
		write_reg(CFG_LIMIT_LOW, lo);
		write_reg(CFG_LIMIT_HIGH, hi);
		cfg_wen <= 1'b0;
	endtask

	// present one item after a random gap, return at the accepting edge
	task automatic send_item(logic signed [15:0] meas, logic [15:0] dt);
		int gap;
		gap = calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		measurement <= meas;
		elapsed_ms  <= dt;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// wait until every expected drive item is back, then let the block go quiet
	task automatic settle(int hold);
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (hold) @(posedge clk);
	endtask

	// result side: random stall before each item, then ready until it is taken
	initial begin : result_sink
		int stall;
		out_ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, MAX_GAP);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	initial begin : stimulus
		int                 ph, n, kind, r;
		logic signed [15:0] gp, gi, gd, tgt, lo, hi, meas;
		logic [15:0]        dt;

		cfg_wen     <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		measurement <= '0;
		elapsed_ms  <= '0;
		arst_n      <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unit gains, moderate limits
		load_settings(16'sd256, 16'sd256, 16'sd256, 16'sd100, -16'sd1000, 16'sd1000);
		send_item(16'sd100, 16'd1000);      // zero error
		send_item(-16'sd32768, 16'd0);      // lowest measurement, zero elapsed time
		send_item(16'sd32767, 16'd1);       // highest measurement, shortest step
		send_item(16'sd0, 16'd65535);       // longest step
		send_item(16'sd100, 16'd0);         // error change seen across a zero step
		send_item(16'sd50, 16'd10);
		settle(SETTLE_CYCLES);

		// all positive extremes, widest limits
		load_settings(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767);
		send_item(-16'sd32768, 16'd65535);  // largest error
		send_item(16'sd32767, 16'd65535);
		send_item(-16'sd32768, 16'd1);      // largest error swing over one ms
		send_item(16'sd0, 16'd0);
		settle(SETTLE_CYCLES);

		// negative extremes for the gains, the target and the low limit
		load_settings(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
			16'sd32767);
		send_item(16'sd32767, 16'd1);
		send_item(-16'sd32768, 16'd65535);
		send_item(16'sd0, 16'd1000);
		settle(SETTLE_CYCLES);

		// crossed limits, every value lands on one of them
		load_settings(16'sd256, 16'sd128, 16'sd64, 16'sd0, 16'sd100, -16'sd100);
		send_item(16'sd0, 16'd10);
		send_item(16'sd50, 16'd10);
		send_item(-16'sd50, 16'd10);
		send_item(16'sd0, 16'd0);
		settle(SETTLE_CYCLES);

		// zero gains and equal limits
		load_settings(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_item(16'sd1234, 16'd10);
		send_item(-16'sd1, 16'd0);
		settle(SETTLE_CYCLES);

		// random phases: mostly a loop tracking near its target with small gains,
		// some with narrow or crossed limits, some with everything random
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			kind = $urandom_range(0, 3);
			calm = ($urandom_range(0, 3) == 0);
			if (kind == 3) begin
				gp  = 16'($urandom);
				gi  = 16'($urandom);
				gd  = 16'($urandom);
				tgt = 16'($urandom);
				lo  = 16'($urandom);
				hi  = 16'($urandom);
			end else begin
				gp  = 16'(int'($urandom_range(0, 2048)) - 1024);
				gi  = 16'(int'($urandom_range(0, 2048)) - 1024);
				gd  = 16'(int'($urandom_range(0, 512)) - 256);
				tgt = 16'(int'($urandom_range(0, 8000)) - 4000);
				if (kind == 2) begin
					// narrow window, sometimes crossed
					lo = 16'(int'($urandom_range(0, 400)) - 200);
					hi = 16'(int'($urandom_range(0, 400)) - 200);
				end else begin
					lo = 16'(-int'($urandom_range(0, 32768)));
					hi = 16'($urandom_range(0, 32767));
				end
			end
			load_settings(gp, gi, gd, tgt, lo, hi);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 9);
				if (kind == 3 || r == 0) begin
					meas = 16'($urandom);
					dt   = 16'($urandom);
				end else begin
					meas = 16'(int'(tgt) + int'($urandom_range(0, 1000)) - 500);
					if (r == 1)
						dt = '0;
					else if (r == 2)
						dt = 16'($urandom);
					else
						dt = 16'($urandom_range(1, 50));
				end
				send_item(meas, dt);
			end
			settle(SETTLE_CYCLES);
		end

		calm = 1'b0;
		settle(TAIL_CYCLES);
		if (failures == 0 && pending == 0)
			$display("pid_controller_clamped_unit test passed");
		else
			$display("pid_controller_clamped_unit test failed");
		$finish;
	end

endmodule
